/* rtl/csfw_pkg.sv */
// ----------------------------------------------------------------------------
// csfw_pkg
// Request kinds, result codes and the command/status bundles shared between
// the semaphore control and its waiter queue.
// ----------------------------------------------------------------------------
package csfw_pkg;

   localparam int ID_W     = 4;
   localparam int NUM_IDS  = 1 << ID_W;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 16;   // width of the reported count
   localparam int WAITERS_W = 5;   // width of the reported queue length

   typedef enum logic [1:0] {
      REQ_POST   = 2'd0,
      REQ_WAIT   = 2'd1,
      REQ_TRY    = 2'd2,
      REQ_CANCEL = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_QUEUED    = 3'd1,
      ST_REFUSED   = 3'd2,
      ST_REMOVED   = 3'd3,
      ST_RELEASED  = 3'd4,
      ST_FULL      = 3'd5,
      ST_SATURATED = 3'd6,
      ST_DUPLICATE = 3'd7
   } status_type;

   typedef struct packed {
      logic push;     // append id at the tail
      logic pop;      // drop the head
      logic cancel;   // drop id wherever it sits
   } q_cmd_type;

   typedef struct packed {
      logic            empty;
      logic            full;
      logic            hit;      // id is currently queued
      logic [ID_W-1:0] head_id;
   } q_stat_type;

endpackage

/* rtl/csfw_queue.sv */
// ----------------------------------------------------------------------------
// csfw_queue
// Ordered waiter queue: tail append, head pop and removal from any position
// with compaction toward the head. A membership bitmap
// over the id space answers duplicate and cancel lookups.
// ----------------------------------------------------------------------------
module csfw_queue #(
   parameter int MAX_WAITERS = 16,
   localparam int OccW = $clog2(MAX_WAITERS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  csfw_pkg::q_cmd_type           cmd,
   input  logic [csfw_pkg::ID_W-1:0]     id,
   output csfw_pkg::q_stat_type          stat,
   output logic [OccW-1:0]               occ_next
);

   logic [csfw_pkg::ID_W-1:0]    slot_ff [MAX_WAITERS];
   logic [csfw_pkg::ID_W-1:0]    slot_in [MAX_WAITERS];
   logic [OccW-1:0]              occ_ff;
   logic [OccW-1:0]              occ_in;
   logic [csfw_pkg::NUM_IDS-1:0] member_ff;
   logic [csfw_pkg::NUM_IDS-1:0] member_in;

   logic [MAX_WAITERS-1:0] live;
   logic [MAX_WAITERS-1:0] rm_vec;
   logic [MAX_WAITERS-1:0] shift;
   logic [MAX_WAITERS-1:0] tail;
   logic                   do_rm;
   logic                   do_push;

   assign stat.empty   = (occ_ff == '0);
   assign stat.full    = (occ_ff == OccW'(MAX_WAITERS));
   assign stat.hit     = member_ff[id];
   assign stat.head_id = slot_ff[0];

   assign do_push = cmd.push & ~stat.full;
   assign do_rm   = (cmd.pop & ~stat.empty) | (cmd.cancel & stat.hit);

   for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_slot
      assign live[i]   = (OccW'(i) < occ_ff);
      assign tail[i]   = (OccW'(i) == occ_ff);
      // ids in the queue are unique, so at most one live slot matches
      if (i == 0) begin : g_head
         assign rm_vec[i] = cmd.pop | (cmd.cancel & live[i] & (slot_ff[i] == id));
      end else begin : g_body
         assign rm_vec[i] = ~cmd.pop & cmd.cancel & live[i] & (slot_ff[i] == id);
      end
      // every slot at or behind the removed one takes its younger neighbor
      assign shift[i] = do_rm & (|rm_vec[i:0]);

      if (i < MAX_WAITERS - 1) begin : g_mid
         always_comb begin
            if (shift[i]) begin
               slot_in[i] = slot_ff[i + 1];
            end else if (do_push && tail[i]) begin
               slot_in[i] = id;
            end else begin
               slot_in[i] = slot_ff[i];
            end
         end
      end else begin : g_last
         always_comb begin
            if (do_push && tail[i]) begin
               slot_in[i] = id;
            end else begin
               slot_in[i] = slot_ff[i];
            end
         end
      end
   end

   always_comb begin
      member_in = member_ff;
      occ_in    = occ_ff;
      if (do_push) begin
         member_in[id] = 1'b1;
         occ_in        = occ_ff + OccW'(1);
      end else if (do_rm) begin
         if (cmd.pop) begin
            member_in[slot_ff[0]] = 1'b0;
         end else begin
            member_in[id] = 1'b0;
         end
         occ_in = occ_ff - OccW'(1);
      end
   end

   assign occ_next = occ_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         member_ff <= '0;
      end else begin
         occ_ff    <= occ_in;
         member_ff <= member_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

/* rtl/counting_semaphore_fifo_waiters_unit.sv */
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_unit
// Counting semaphore with a first-in first-out queue of waiter ids.
// ----------------------------------------------------------------------------
// A request (post, wait, try-wait, cancel) is taken whenever start is high
// and busy is low; busy is only high during reset and the cycle after it,
// so one request can be issued every clock. Each request yields exactly one
// response: the request is first captured in the request register, then the
// count, the queue and the response register update together from it, and
// rsp_valid is high for a single cycle for each response. The receiver
// cannot stall and must take each response when rsp_valid is high.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_unit #(
   parameter int MAX_WAITERS = 16,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [csfw_pkg::ID_W-1:0]           req_waiter_id,
   output logic                                rsp_valid,
   output logic [csfw_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_woken_valid,
   output logic [csfw_pkg::ID_W-1:0]           rsp_woken_id,
   output logic [csfw_pkg::COUNT_W-1:0]        rsp_count_now,
   output logic [csfw_pkg::WAITERS_W-1:0]      rsp_waiters_now
);

   localparam int OccW = $clog2(MAX_WAITERS + 1);

   logic                        busy_ff;
   logic                        req_valid_ff;
   csfw_pkg::req_kind_type      req_kind_ff;
   logic [csfw_pkg::ID_W-1:0]   req_id_ff;

   logic [COUNT_BITS-1:0]       cnt_ff;
   logic [COUNT_BITS-1:0]       cnt_in;

   csfw_pkg::q_cmd_type         q_cmd;
   csfw_pkg::q_stat_type        q_stat;
   logic [OccW-1:0]             occ_next;

   csfw_pkg::status_type        status_in;
   logic                        woken_in;
   logic [csfw_pkg::ID_W-1:0]   woken_id_in;
   logic                        fast;

   logic                        rsp_valid_ff;
   csfw_pkg::status_type        rsp_status_ff;
   logic                        rsp_woken_ff;
   logic [csfw_pkg::ID_W-1:0]   rsp_woken_id_ff;
   logic [csfw_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [csfw_pkg::WAITERS_W-1:0] rsp_waiters_ff;

   assign busy = busy_ff;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start & ~busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      req_kind_ff <= csfw_pkg::req_kind_type'(req_type);
      req_id_ff   <= req_waiter_id;
   end

   csfw_queue #(
      .MAX_WAITERS (MAX_WAITERS)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd      (q_cmd),
      .id       (req_id_ff),
      .stat     (q_stat),
      .occ_next (occ_next)
   );

   assign fast = q_stat.empty & (cnt_ff != '0);

   always_comb begin
      q_cmd       = '0;
      cnt_in      = cnt_ff;
      status_in   = csfw_pkg::ST_GRANTED;
      woken_in    = 1'b0;
      woken_id_in = '0;
      if (req_valid_ff) begin
         case (req_kind_ff)
            csfw_pkg::REQ_POST: begin
               if (!q_stat.empty) begin
                  q_cmd.pop   = 1'b1;
                  woken_in    = 1'b1;
                  woken_id_in = q_stat.head_id;
               end else if (cnt_ff == '1) begin
                  status_in = csfw_pkg::ST_SATURATED;
               end else begin
                  cnt_in = cnt_ff + COUNT_BITS'(1);
               end
            end
            csfw_pkg::REQ_WAIT: begin
               if (q_stat.hit) begin
                  status_in = csfw_pkg::ST_DUPLICATE;
               end else if (fast) begin
                  cnt_in = cnt_ff - COUNT_BITS'(1);
               end else if (q_stat.full) begin
                  status_in = csfw_pkg::ST_FULL;
               end else begin
                  q_cmd.push = 1'b1;
                  status_in  = csfw_pkg::ST_QUEUED;
               end
            end
            csfw_pkg::REQ_TRY: begin
               if (fast) begin
                  cnt_in = cnt_ff - COUNT_BITS'(1);
               end else begin
                  status_in = csfw_pkg::ST_REFUSED;
               end
            end
            csfw_pkg::REQ_CANCEL: begin
               if (q_stat.hit) begin
                  q_cmd.cancel = 1'b1;
                  status_in    = csfw_pkg::ST_REMOVED;
               end else begin
                  status_in = csfw_pkg::ST_RELEASED;
               end
            end
            default: begin
               status_in = csfw_pkg::ST_GRANTED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff   <= status_in;
      rsp_woken_ff    <= woken_in;
      rsp_woken_id_ff <= woken_id_in;
      rsp_count_ff    <= csfw_pkg::COUNT_W'(cnt_in);
      rsp_waiters_ff  <= csfw_pkg::WAITERS_W'(occ_next);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_woken_valid = rsp_woken_ff;
   assign rsp_woken_id    = rsp_woken_id_ff;
   assign rsp_count_now   = rsp_count_ff;
   assign rsp_waiters_now = rsp_waiters_ff;

endmodule

/* rtl/csfw_checker.sv */
// ----------------------------------------------------------------------------
// csfw_checker
// Port-level checks on request/response timing and response consistency.
// ----------------------------------------------------------------------------
module csfw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [csfw_pkg::STATUS_W-1:0]  rsp_status,
   input logic                           rsp_woken_valid
);

   // every accepted request gets its response, through the request and response registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("request accepted without a response two cycles later");

   // no response without a request behind it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without a matching request");

   // a woken waiter only comes with a granted post
   a_woken_granted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_woken_valid) |->
         (rsp_status == csfw_pkg::ST_GRANTED))
      else $error("woken waiter reported with a non-granted status");

   // saturated, refused and full failures never release a waiter
   a_fail_no_wake: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == csfw_pkg::ST_SATURATED ||
                     rsp_status == csfw_pkg::ST_REFUSED ||
                     rsp_status == csfw_pkg::ST_FULL)) |-> !rsp_woken_valid)
      else $error("failed request reported a woken waiter");

endmodule

bind counting_semaphore_fifo_waiters_unit csfw_checker u_csfw_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_woken_valid (rsp_woken_valid)
);
